// ----- design/frrc_pkg.sv -----
// Shared types, constants and CRC functions of the FlexRay frame receive checker.
package frrc_pkg;

    // Field widths.
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 9;
    localparam int LEN_W       = 10;
    localparam int HDR_W       = 40;
    localparam int HCRC_W      = 11;
    localparam int FCRC_W      = 24;
    localparam int STATUS_W    = 3;

    // Frame layout.
    localparam int                HDR_BYTES   = 5;
    localparam int                FCRC_BYTES  = 3;
    localparam logic [POS_W-1:0]  POS_MAX     = 9'd511;

    // CRC definitions, both MSB first.
    localparam logic [HCRC_W-1:0] HDR_CRC_INIT = 11'h01A;
    localparam logic [HCRC_W-1:0] HDR_CRC_POLY = 11'h385;
    localparam logic [FCRC_W-1:0] FRM_CRC_INIT = 24'hFEDCBA;
    localparam logic [FCRC_W-1:0] FRM_CRC_POLY = 24'h5D6DCB;

    // Configuration port.
    localparam int                PADDR_W             = 3;
    localparam int                PDATA_W             = 32;
    localparam logic              CFG_IDX_MAX_PAYLOAD = 1'b0;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET   = 8'd254;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Summary status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERSIZE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_HCRC_BAD = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FCRC_BAD = 3'd4;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_slice;
        logic [3:0] source_tag;
    } in_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [10:0] frame_ident;
        logic [4:0]  indicators;
        logic [6:0]  payload_words;
        logic [5:0]  cycle_num;
        logic [3:0]  source_out;
        logic [23:0] rx_frm_crc;
        logic [2:0]  status;
    } out_item_t;

    // One classified item as it waits between the front and the back.
    typedef struct packed {
        logic              item_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [HDR_W-1:0]  header;
        logic [3:0]        source_tag;
        logic [FCRC_W-1:0] crc_field;
        logic [HCRC_W-1:0] hdr_crc_calc;
        logic [FCRC_W-1:0] frm_crc_calc;
        logic [LEN_W-1:0]  byte_total;
    } q_entry_t;

    // Runs the header CRC over the top nbits of data, MSB first.
    function automatic logic [HCRC_W-1:0] crc11_update(
        input logic [HCRC_W-1:0] crc,
        input logic [7:0]        data,
        input logic [3:0]        nbits
    );
        logic [HCRC_W-1:0] c;
        logic              fb;
        c  = crc;
        fb = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(nbits)) begin
                fb = c[HCRC_W-1] ^ data[7-i];
                c  = {c[HCRC_W-2:0], 1'b0};
                if (fb) begin
                    c = c ^ HDR_CRC_POLY;
                end
            end
        end
        return c;
    endfunction

    // Runs the frame CRC over one byte, MSB first.
    function automatic logic [FCRC_W-1:0] crc24_byte(
        input logic [FCRC_W-1:0] crc,
        input logic [7:0]        data
    );
        logic [FCRC_W-1:0] c;
        logic              fb;
        c  = crc;
        fb = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            fb = c[FCRC_W-1] ^ data[i];
            c  = {c[FCRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ FRM_CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ----- design/frrc_front.sv -----
// Front part: takes frame bytes, tracks the slice and both CRCs, and classifies each byte.
module frrc_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  frrc_pkg::in_item_t          s_data,
    input  logic [frrc_pkg::BYTE_W-1:0] max_payload,
    input  logic                        q_full,
    output logic                        q_push,
    output frrc_pkg::q_entry_t          q_wdata
);

    logic [frrc_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [frrc_pkg::HDR_W-1:0]  hdr_reg,  hdr_next;
    logic [frrc_pkg::HCRC_W-1:0] hcrc_reg, hcrc_next;
    logic [frrc_pkg::FCRC_W-1:0] fcrc_reg, fcrc_next;
    logic [frrc_pkg::FCRC_W-1:0] cfld_reg, cfld_next;

    logic [frrc_pkg::HDR_W-1:0]  hdr_upd;
    logic [frrc_pkg::HCRC_W-1:0] hcrc_upd;
    logic [frrc_pkg::FCRC_W-1:0] fcrc_upd;
    logic [frrc_pkg::FCRC_W-1:0] cfld_upd;
    logic [frrc_pkg::POS_W-1:0]  pos_upd;
    logic [6:0]                  pw;
    logic [frrc_pkg::BYTE_W-1:0] plen;
    logic [frrc_pkg::POS_W-1:0]  frame_end;
    logic [frrc_pkg::POS_W-1:0]  crc_end;
    logic                        in_frame;
    logic                        in_crc_field;
    logic                        is_payload;
    logic                        accept;
    logic [7:0]                  b;

    assign b       = s_data.frame_byte;
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Header capture and header CRC over the 20 protected bits.
    always_comb begin
        hdr_upd  = hdr_reg;
        hcrc_upd = hcrc_reg;
        unique case (pos_reg)
            9'd0: begin
                hdr_upd[39:32] = b;
                hcrc_upd = frrc_pkg::crc11_update(hcrc_reg, {b[4:0], 3'b000}, 4'd5);
            end
            9'd1: begin
                hdr_upd[31:24] = b;
                hcrc_upd = frrc_pkg::crc11_update(hcrc_reg, b, 4'd8);
            end
            9'd2: begin
                hdr_upd[23:16] = b;
                hcrc_upd = frrc_pkg::crc11_update(hcrc_reg, {b[7:1], 1'b0}, 4'd7);
            end
            9'd3: hdr_upd[15:8] = b;
            9'd4: hdr_upd[7:0]  = b;
            default: begin
            end
        endcase
    end

    assign pw        = hdr_upd[23:17];
    assign plen      = {pw, 1'b0};
    assign frame_end = {1'b0, plen} + 9'(frrc_pkg::HDR_BYTES);
    assign crc_end   = frame_end + 9'(frrc_pkg::FCRC_BYTES);
    assign in_frame  = pos_reg < frame_end;
    assign in_crc_field = !in_frame && (pos_reg < crc_end);
    assign is_payload   = in_frame && (pos_reg >= 9'(frrc_pkg::HDR_BYTES));

    assign fcrc_upd = in_frame ? frrc_pkg::crc24_byte(fcrc_reg, b) : fcrc_reg;
    assign cfld_upd = in_crc_field ? {cfld_reg[15:0], b} : cfld_reg;
    assign pos_upd  = (pos_reg == frrc_pkg::POS_MAX) ? frrc_pkg::POS_MAX : pos_reg + 9'd1;

    always_comb begin
        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        hcrc_next = hcrc_reg;
        fcrc_next = fcrc_reg;
        cfld_next = cfld_reg;
        if (accept) begin
            if (s_data.end_of_slice) begin
                pos_next  = '0;
                hdr_next  = '0;
                hcrc_next = frrc_pkg::HDR_CRC_INIT;
                fcrc_next = frrc_pkg::FRM_CRC_INIT;
                cfld_next = '0;
            end else begin
                pos_next  = pos_upd;
                hdr_next  = hdr_upd;
                hcrc_next = hcrc_upd;
                fcrc_next = fcrc_upd;
                cfld_next = cfld_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            hdr_reg  <= '0;
            hcrc_reg <= frrc_pkg::HDR_CRC_INIT;
            fcrc_reg <= frrc_pkg::FRM_CRC_INIT;
            cfld_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            hdr_reg  <= hdr_next;
            hcrc_reg <= hcrc_next;
            fcrc_reg <= fcrc_next;
            cfld_reg <= cfld_next;
        end
    end

    // A summary goes out on the slice end; a payload byte only if the payload fits.
    assign q_push = accept &&
                    (s_data.end_of_slice || (is_payload && (plen <= max_payload)));

    always_comb begin
        q_wdata               = '0;
        q_wdata.item_kind     = s_data.end_of_slice ? frrc_pkg::KIND_SUMMARY
                                                    : frrc_pkg::KIND_PAYLOAD;
        q_wdata.payload_byte  = b;
        q_wdata.payload_index = 8'(pos_reg - 9'(frrc_pkg::HDR_BYTES));
        q_wdata.header        = hdr_upd;
        q_wdata.source_tag    = s_data.source_tag;
        q_wdata.crc_field     = cfld_upd;
        q_wdata.hdr_crc_calc  = hcrc_upd;
        q_wdata.frm_crc_calc  = fcrc_upd;
        q_wdata.byte_total    = {1'b0, pos_reg} + 10'd1;
    end

endmodule

// ----- design/frrc_queue.sv -----
// Short first-in first-out queue of classified items between the front and the back.
module frrc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  frrc_pkg::q_entry_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output frrc_pkg::q_entry_t head
);

    frrc_pkg::q_entry_t          mem_reg [frrc_pkg::QUEUE_DEPTH];
    logic [frrc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [frrc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [frrc_pkg::QCNT_W-1:0] count_reg,  count_next;

    assign full       = count_reg == frrc_pkg::QCNT_W'(frrc_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == frrc_pkg::QPTR_W'(frrc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == frrc_pkg::QPTR_W'(frrc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/frrc_back.sv -----
// Back part: grades each summary, formats the result and holds it in the output register.
module frrc_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        head_valid,
    input  frrc_pkg::q_entry_t          head,
    output logic                        pop,
    input  logic [frrc_pkg::BYTE_W-1:0] max_payload,
    output logic                        m_valid,
    input  logic                        m_ready,
    output frrc_pkg::out_item_t         m_data
);

    logic                m_valid_reg, m_valid_next;
    frrc_pkg::out_item_t m_data_reg;
    frrc_pkg::out_item_t result;

    logic [7:0]                    h0, h1, h2, h3, h4;
    logic [6:0]                    pw;
    logic [7:0]                    plen;
    logic [frrc_pkg::HCRC_W-1:0]   rx_hcrc;
    logic [frrc_pkg::STATUS_W-1:0] status;
    logic                          fcrc_bad;

    assign h0 = head.header[39:32];
    assign h1 = head.header[31:24];
    assign h2 = head.header[23:16];
    assign h3 = head.header[15:8];
    assign h4 = head.header[7:0];
    assign pw      = h2[7:1];
    assign plen    = {pw, 1'b0};
    assign rx_hcrc = {h2[0], h3, h4[7:6]};

    // An empty payload passes only with a received CRC of zero.
    assign fcrc_bad = (pw == '0) ? (head.crc_field != '0)
                                 : (head.frm_crc_calc != head.crc_field);

    always_comb begin
        if (head.byte_total < 10'd8) begin
            status = frrc_pkg::STATUS_SHORT;
        end else if (plen > max_payload) begin
            status = frrc_pkg::STATUS_OVERSIZE;
        end else if (head.byte_total < ({2'b00, plen} + 10'd8)) begin
            status = frrc_pkg::STATUS_SHORT;
        end else if (head.hdr_crc_calc != rx_hcrc) begin
            status = frrc_pkg::STATUS_HCRC_BAD;
        end else if (fcrc_bad) begin
            status = frrc_pkg::STATUS_FCRC_BAD;
        end else begin
            status = frrc_pkg::STATUS_OK;
        end
    end

    always_comb begin
        result = '0;
        result.item_kind = head.item_kind;
        if (head.item_kind == frrc_pkg::KIND_SUMMARY) begin
            result.frame_ident   = {h0[2:0], h1};
            result.indicators    = h0[7:3];
            result.payload_words = pw;
            result.cycle_num     = h4[5:0];
            result.source_out    = head.source_tag;
            result.status        = status;
            if (status == frrc_pkg::STATUS_SHORT || status == frrc_pkg::STATUS_OVERSIZE) begin
                result.rx_frm_crc = '0;
            end else begin
                result.rx_frm_crc = head.crc_field;
            end
        end else begin
            result.payload_byte  = head.payload_byte;
            result.payload_index = head.payload_index;
        end
    end

    assign pop = head_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- design/flexray_frame_receive_checker.sv -----
// Top level of the FlexRay frame receive checker: configuration register, front, queue, back.
//
//   Channel  Direction  Ports                       Carries
//   s_       in         s_valid s_ready s_data      one received frame byte per transfer
//   m_       out        m_valid m_ready m_data      a payload byte or a frame summary
//   APB      in/out     psel penable pwrite paddr   max_payload_bytes at address 0
//                       pwdata prdata pready
//
// One byte is taken per cycle while the queue is not full. A result passes through the queue
// and the output register before m_valid rises, so it never leaves in the cycle of its byte.
// The byte-wise CRC-11 and CRC-24 updates and the header capture all settle in the cycle of
// the transfer, so the slice state is ready for the next byte at once.
// Reset (aresetn low at a clock edge) empties the queue and the output register, clears the
// slice state and sets max_payload_bytes to 254.
// A stall on m_ readies fill the two-entry queue; s_ready falls only when the queue is full.

module flexray_frame_receive_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  frrc_pkg::in_item_t            s_data,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output frrc_pkg::out_item_t           m_data,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frrc_pkg::PADDR_W-1:0]  paddr,
    input  logic [frrc_pkg::PDATA_W-1:0]  pwdata,
    output logic [frrc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // The register index is the word address; the low two address bits select nothing.
    logic [frrc_pkg::BYTE_W-1:0] max_payload_reg, max_payload_next;
    logic                        cfg_write;
    logic                        cfg_hit;

    frrc_pkg::q_entry_t q_wdata;
    frrc_pkg::q_entry_t q_head;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_head_valid;

    assign pready    = 1'b1;
    assign cfg_hit   = paddr[2] == frrc_pkg::CFG_IDX_MAX_PAYLOAD;
    assign cfg_write = psel && penable && pwrite && cfg_hit;

    // Writes beyond the register list are completed but change nothing, and read as zero.
    assign prdata = cfg_hit ? {{(frrc_pkg::PDATA_W - frrc_pkg::BYTE_W){1'b0}}, max_payload_reg}
                            : '0;

    always_comb begin
        max_payload_next = max_payload_reg;
        if (cfg_write) begin
            max_payload_next = pwdata[frrc_pkg::BYTE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= frrc_pkg::MAX_PAYLOAD_RESET;
        end else begin
            max_payload_reg <= max_payload_next;
        end
    end

    // The front decides per byte whether a result follows and pushes it with the CRC state
    // that the byte leaves behind.
    frrc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .max_payload (max_payload_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    frrc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .wdata      (q_wdata),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // The back grades each summary against the received CRC fields and the size limit.
    frrc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_head_valid),
        .head        (q_head),
        .pop         (q_pop),
        .max_payload (max_payload_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ----- test/frrc_result_checker.sv -----
// Scoreboard for the FlexRay frame receive checker: predicts every result and compares it.
module frrc_result_checker
    import frrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_item_t           s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_item_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    output int unsigned        error_count,
    output int unsigned        waiting_count,
    output int unsigned        summary_count,
    output int unsigned        payload_count
);

    localparam logic [PADDR_W-1:0] MAX_PAYLOAD_ADDR = PADDR_W'(4 * CFG_IDX_MAX_PAYLOAD);
    localparam int                 REPORT_LIMIT     = 10;
    localparam int                 MIN_FRAME_BYTES  = HDR_BYTES + FCRC_BYTES;

    // Slice state as the block should hold it.
    logic [POS_W-1:0]  slice_pos;
    logic [HDR_W-1:0]  header_bytes;
    logic [HCRC_W-1:0] hdr_crc_acc;
    logic [FCRC_W-1:0] body_crc;
    logic [FCRC_W-1:0] crc_field;
    logic [7:0]        max_payload;
    out_item_t         expected_results [$];
    int unsigned       results_seen;

    // Header CRC over the low n bits of data, most significant first.
    function automatic logic [HCRC_W-1:0] hdr_crc_step(input logic [HCRC_W-1:0] crc,
                                                        input logic [7:0] data, input int n);
        logic [HCRC_W-1:0] c;
        c = crc;
        for (int i = n - 1; i >= 0; i--) begin
            if (c[HCRC_W-1] ^ data[i]) begin
                c = (c << 1) ^ HDR_CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    function automatic logic [FCRC_W-1:0] body_crc_step(input logic [FCRC_W-1:0] crc,
                                                         input logic [7:0] data);
        logic [FCRC_W-1:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            if (c[FCRC_W-1] ^ data[i]) begin
                c = (c << 1) ^ FRM_CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    task automatic start_slice();
        slice_pos    = '0;
        header_bytes = '0;
        hdr_crc_acc  = HDR_CRC_INIT;
        body_crc     = FRM_CRC_INIT;
        crc_field    = '0;
    endtask

    // Advances the slice state by one accepted byte and queues the result it causes.
    task automatic predict_byte(input in_item_t it);
        logic [7:0]          b;
        logic [7:0]          h0, h1, h2, h3, h4;
        logic [HCRC_W-1:0]   rx_hcrc;
        logic [STATUS_W-1:0] st;
        logic                in_payload;
        int                  pos, pw, plen, len;
        out_item_t           r;
        b          = it.frame_byte;
        pos        = int'(slice_pos);
        in_payload = 1'b0;
        if (pos < HDR_BYTES) begin
            header_bytes[HDR_W-1-8*pos -: 8] = b;
        end
        // The header CRC protects the low five bits of byte 0, byte 1 and the top of byte 2.
        if (pos == 0) begin
            hdr_crc_acc = hdr_crc_step(hdr_crc_acc, b, 5);
        end else if (pos == 1) begin
            hdr_crc_acc = hdr_crc_step(hdr_crc_acc, b, 8);
        end else if (pos == 2) begin
            hdr_crc_acc = hdr_crc_step(hdr_crc_acc, b >> 1, 7);
        end
        pw   = int'(header_bytes[23:17]);
        plen = 2 * pw;
        if (pos < HDR_BYTES + plen) begin
            body_crc   = body_crc_step(body_crc, b);
            in_payload = (pos >= HDR_BYTES);
        end else if (pos < MIN_FRAME_BYTES + plen) begin
            crc_field = {crc_field[15:0], b};
        end
        len       = pos + 1;
        slice_pos = (len > int'(POS_MAX)) ? POS_MAX : POS_W'(len);
        r = '0;
        if (it.end_of_slice) begin
            h0      = header_bytes[39:32];
            h1      = header_bytes[31:24];
            h2      = header_bytes[23:16];
            h3      = header_bytes[15:8];
            h4      = header_bytes[7:0];
            rx_hcrc = {h2[0], h3, h4[7:6]};
            if (len < MIN_FRAME_BYTES) begin
                st = STATUS_SHORT;
            end else if (plen > int'(max_payload)) begin
                st = STATUS_OVERSIZE;
            end else if (len < MIN_FRAME_BYTES + plen) begin
                st = STATUS_SHORT;
            end else if (hdr_crc_acc != rx_hcrc) begin
                st = STATUS_HCRC_BAD;
            end else if (pw == 0 ? crc_field != '0 : body_crc != crc_field) begin
                st = STATUS_FCRC_BAD;
            end else begin
                st = STATUS_OK;
            end
            r.item_kind     = KIND_SUMMARY;
            r.frame_ident   = {h0[2:0], h1};
            r.indicators    = h0[7:3];
            r.payload_words = 7'(pw);
            r.cycle_num     = h4[5:0];
            r.source_out    = it.source_tag;
            r.rx_frm_crc    = (st == STATUS_SHORT || st == STATUS_OVERSIZE) ? '0 : crc_field;
            r.status        = st;
            expected_results.push_back(r);
            start_slice();
        end else if (in_payload && plen <= int'(max_payload)) begin
            r.item_kind     = KIND_PAYLOAD;
            r.payload_byte  = b;
            r.payload_index = 8'(pos - HDR_BYTES);
            expected_results.push_back(r);
        end
    endtask

    task automatic report(input string what, input logic [23:0] want_v, input logic [23:0] got_v);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, what, want_v, got_v);
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
                $display("result %0d arrived with nothing expected: 0x%0h", results_seen, got);
            end
        end else begin
            want = expected_results.pop_front();
            if (want.item_kind == KIND_SUMMARY) begin
                summary_count++;
            end else begin
                payload_count++;
            end
            if (got.item_kind != want.item_kind) begin
                report("item_kind", want.item_kind, got.item_kind);
            end
            if (got.payload_byte != want.payload_byte) begin
                report("payload_byte", want.payload_byte, got.payload_byte);
            end
            if (got.payload_index != want.payload_index) begin
                report("payload_index", want.payload_index, got.payload_index);
            end
            if (got.frame_ident != want.frame_ident) begin
                report("frame_ident", want.frame_ident, got.frame_ident);
            end
            if (got.indicators != want.indicators) begin
                report("indicators", want.indicators, got.indicators);
            end
            if (got.payload_words != want.payload_words) begin
                report("payload_words", want.payload_words, got.payload_words);
            end
            if (got.cycle_num != want.cycle_num) begin
                report("cycle_num", want.cycle_num, got.cycle_num);
            end
            if (got.source_out != want.source_out) begin
                report("source_out", want.source_out, got.source_out);
            end
            if (got.rx_frm_crc != want.rx_frm_crc) begin
                report("rx_frm_crc", want.rx_frm_crc, got.rx_frm_crc);
            end
            if (got.status != want.status) begin
                report("status", want.status, got.status);
            end
        end
    endtask

    // A result never leaves in the cycle of its own byte, so checking before predicting is safe.
    always @(posedge aclk) begin
        if (!aresetn) begin
            start_slice();
            max_payload = MAX_PAYLOAD_RESET;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (psel && penable && pwrite && pready && paddr == MAX_PAYLOAD_ADDR) begin
                max_payload = pwdata[7:0];
            end
            if (s_valid && s_ready) begin
                predict_byte(s_data);
            end
        end
        waiting_count = expected_results.size();
    end

endmodule

// ----- test/flexray_frame_receive_checker_tb.sv -----
// Testbench top for the FlexRay frame receive checker: clock, reset, stimulus and verdict.
module flexray_frame_receive_checker_tb;
    import frrc_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_ITEMS     = 1350;
    localparam int PHASES           = 4;
    localparam int HOLD_CYCLES      = 200;
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_SLICE_BYTES = 600;
    // The long slice is part of the byte total, so the random frames share the rest.
    localparam int ITEMS_PER_PHASE  = (RANDOM_ITEMS - LONG_SLICE_BYTES) / PHASES;
    localparam logic [PADDR_W-1:0] MAX_PAYLOAD_ADDR = PADDR_W'(4 * CFG_IDX_MAX_PAYLOAD);

    // How a slice is built: a well-formed frame, a frame with one thing broken, or plain noise.
    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_HDR_CRC,
        FRAME_BAD_BODY_CRC,
        FRAME_CUT_SHORT,
        FRAME_TRAILING,
        FRAME_NOISE,
        FRAME_LONG
    } frame_shape_e;

    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZEROS,
        FILL_ONES
    } fill_e;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int unsigned error_count;
    int unsigned waiting_count;
    int unsigned summary_count;
    int unsigned payload_count;

    // Shared between the sender and the receiver. A quiet spell turns off idling on both
    // sides; a hold-off request makes the receiver stop taking results for a long stretch.
    bit          quiet_spell      = 1'b0;
    bit          hold_off_request = 1'b0;
    int unsigned bytes_sent       = 0;
    int unsigned slices_sent      = 0;
    in_item_t    slice_bytes [$];

    flexray_frame_receive_checker i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The checker watches both channels and the register port on its own; the top only
    // reads back how many mismatches it found and how many results are still owed.
    frrc_result_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .waiting_count (waiting_count),
        .summary_count (summary_count),
        .payload_count (payload_count)
    );

    initial begin : clock_gen
        forever begin
            #(CLK_PERIOD / 2) aclk = ~aclk;
        end
    end

    // Idle length for either side: mostly none, sometimes a few cycles, rarely a long gap.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(99);
        if (quiet_spell || roll < 70) begin
            return 0;
        end else if (roll < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Payload length in words: mostly short frames, a few medium and a few near the maximum.
    function automatic int pick_words();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) begin
            return $urandom_range(0, 6);
        end else if (roll < 95) begin
            return $urandom_range(7, 24);
        end
        return $urandom_range(100, 127);
    endfunction

    // One register write: a setup cycle, then an access cycle whose closing edge does the write.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offers one byte and holds it until the transfer. Ready is looked at on the falling
    // edge, where it has settled, so the transfer is the rising edge that follows.
    task automatic offer(input in_item_t it);
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(negedge aclk);
        end while (!s_ready);
        @(posedge aclk);
        bytes_sent++;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_stream();
        foreach (slice_bytes[k]) begin
            offer(slice_bytes[k]);
        end
        slices_sent++;
    endtask

    // Drops valid and waits until every expected result has come back, then gives bytes
    // that cause no result time to leave the block before a register write.
    task automatic settle();
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (waiting_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Builds one slice into slice_bytes. Header and frame CRCs are computed so that a good
    // frame passes; the other shapes then break exactly one thing about it, or noise replaces it.
    task automatic build_frame(input frame_shape_e shape, input int words, input fill_e fill);
        logic [7:0]        hb [HDR_BYTES];
        logic [7:0]        raw [$];
        logic [4:0]        ind;
        logic [10:0]       id;
        logic [5:0]        cyc;
        logic [HCRC_W-1:0] hc;
        logic [FCRC_W-1:0] fc;
        logic [7:0]        pb;
        int                keep;
        in_item_t          it;
        ind = 5'($urandom);
        id  = 11'($urandom);
        cyc = 6'($urandom);
        if (fill == FILL_ZEROS) begin
            ind = '0;
            id  = '0;
            cyc = '0;
        end else if (fill == FILL_ONES) begin
            ind = '1;
            id  = '1;
            cyc = '1;
        end
        hb[0] = {ind, id[10:8]};
        hb[1] = id[7:0];
        hb[2] = {7'(words), 1'b0};
        hc = crc11_update(HDR_CRC_INIT, {hb[0][4:0], 3'b000}, 4'd5);
        hc = crc11_update(hc, hb[1], 4'd8);
        hc = crc11_update(hc, hb[2], 4'd7);
        if (shape == FRAME_BAD_HDR_CRC) begin
            hc = hc ^ (HCRC_W'(1) << $urandom_range(HCRC_W - 1));
        end
        hb[2][0] = hc[10];
        hb[3]    = hc[9:2];
        hb[4]    = {hc[1:0], cyc};
        fc = FRM_CRC_INIT;
        for (int k = 0; k < HDR_BYTES; k++) begin
            fc = crc24_byte(fc, hb[k]);
            raw.push_back(hb[k]);
        end
        for (int k = 0; k < 2 * words; k++) begin
            // The all-ones fill alternates full and empty bytes so both extremes pass through.
            if (fill == FILL_RANDOM) begin
                pb = 8'($urandom);
            end else if (fill == FILL_ONES && k % 2 == 0) begin
                pb = 8'hFF;
            end else begin
                pb = 8'h00;
            end
            fc = crc24_byte(fc, pb);
            raw.push_back(pb);
        end
        // An empty payload carries a zero frame CRC.
        if (words == 0) begin
            fc = '0;
        end
        if (shape == FRAME_BAD_BODY_CRC) begin
            fc = fc ^ (FCRC_W'(1) << $urandom_range(FCRC_W - 1));
        end
        raw.push_back(fc[23:16]);
        raw.push_back(fc[15:8]);
        raw.push_back(fc[7:0]);
        case (shape)
            FRAME_CUT_SHORT: begin
                // The end mark lands anywhere before the last CRC byte, payload bytes included.
                keep = $urandom_range(1, raw.size() - 1);
                while (raw.size() > keep) begin
                    void'(raw.pop_back());
                end
            end
            FRAME_TRAILING: begin
                repeat ($urandom_range(1, 6)) raw.push_back(8'($urandom));
            end
            FRAME_LONG: begin
                // Runs well past the point where the byte position saturates.
                while (raw.size() < LONG_SLICE_BYTES) begin
                    raw.push_back(8'($urandom));
                end
            end
            FRAME_NOISE: begin
                raw.delete();
                repeat ($urandom_range(1, 7)) raw.push_back(8'($urandom));
            end
            default: begin
            end
        endcase
        slice_bytes.delete();
        foreach (raw[k]) begin
            it.frame_byte   = raw[k];
            it.end_of_slice = (k == raw.size() - 1);
            it.source_tag   = 4'($urandom);
            slice_bytes.push_back(it);
        end
    endtask

    // Receiver. Most cycles it takes results, sometimes it stalls, and once, on request,
    // it holds off for a long counted stretch while the sender keeps offering bytes.
    initial begin : receiver
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                m_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    @(posedge aclk);
                end
                hold_off_request = 1'b0;
            end else begin
                stall = idle_len();
                if (stall == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (stall - 1) @(posedge aclk);
                end
            end
        end
    end

    // Watchdog: a run that hangs anywhere ends here with a failure.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("flexray_frame_receive_checker test failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]   limits [PHASES];
        int unsigned  budget;
        int           pick;
        frame_shape_e shape;
        limits[0] = MAX_PAYLOAD_RESET;
        limits[1] = 8'd0;
        limits[2] = 8'($urandom_range(2, 252));
        limits[3] = MAX_PAYLOAD_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, still at the reset payload limit: a one-word frame with the indicator,
        // identifier and cycle fields at their top values and payload bytes at both extremes, an
        // empty frame with those fields zero and a zero frame CRC, and a slice too short to hold a frame.
        build_frame(FRAME_GOOD, 1, FILL_ONES);
        send_stream();
        build_frame(FRAME_GOOD, 0, FILL_ZEROS);
        send_stream();
        build_frame(FRAME_NOISE, 0, FILL_RANDOM);
        send_stream();

        // Random part in phases, each under its own payload limit: the largest, zero (every
        // non-empty frame is oversize), one in between, and the largest again.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            apb_write(MAX_PAYLOAD_ADDR, PDATA_W'(limits[ph]));
            budget = bytes_sent + ITEMS_PER_PHASE;
            if (ph == 0) begin
                // A long frame sent back to back while the receiver holds off, so the block
                // fills up and has to refuse transfers on its input.
                hold_off_request = 1'b1;
                quiet_spell      = 1'b1;
                build_frame(FRAME_GOOD, 60, FILL_RANDOM);
                send_stream();
            end
            if (ph == PHASES - 1) begin
                build_frame(FRAME_LONG, 127, FILL_RANDOM);
                send_stream();
                budget = bytes_sent + ITEMS_PER_PHASE;
            end
            while (bytes_sent < budget) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    shape = FRAME_GOOD;
                end else if (pick < 63) begin
                    shape = FRAME_BAD_HDR_CRC;
                end else if (pick < 71) begin
                    shape = FRAME_BAD_BODY_CRC;
                end else if (pick < 83) begin
                    shape = FRAME_CUT_SHORT;
                end else if (pick < 91) begin
                    shape = FRAME_TRAILING;
                end else begin
                    shape = FRAME_NOISE;
                end
                quiet_spell = ($urandom_range(7) == 0);
                build_frame(shape, pick_words(), FILL_RANDOM);
                send_stream();
            end
            quiet_spell = 1'b0;
        end
        settle();

        $display("Sent %0d bytes in %0d slices; checked %0d payload bytes and %0d summaries.",
                 bytes_sent, slices_sent, payload_count, summary_count);
        $display("Payload limits 254, 0, %0d and 254; receiver hold-off of %0d cycles; %0d errors.",
                 limits[2], HOLD_CYCLES, error_count);
        if (error_count == 0 && waiting_count == 0) begin
            $display("flexray_frame_receive_checker test passed");
        end else begin
            $display("flexray_frame_receive_checker test failed");
        end
        $finish;
    end

endmodule
